// ===== rtl/pudrt_pkg.sv =====
// Shared types, register codes and control bit positions of the up/down reload timer.
`timescale 1ns / 1ps
`default_nettype none

package pudrt_pkg;

    // Fixed widths of the bus fields.
    localparam int DATA_W = 16;
    localparam int KIND_W = 2;
    localparam int IDX_W  = 3;

    // Default counter width, handed to the top-level parameter.
    localparam int DEFAULT_COUNTER_WIDTH = 16;

    // Transaction kinds.
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_CTRL   = 3'd0;
    localparam logic [IDX_W-1:0] REG_IRQ_EN = 3'd1;
    localparam logic [IDX_W-1:0] REG_STATUS = 3'd2;
    localparam logic [IDX_W-1:0] REG_EGR    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CNT    = 3'd4;
    localparam logic [IDX_W-1:0] REG_PSC    = 3'd5;
    localparam logic [IDX_W-1:0] REG_ARR    = 3'd6;

    // Control register bit positions.
    localparam int CTL_EN   = 0;
    localparam int CTL_UDIS = 1;
    localparam int CTL_URS  = 2;
    localparam int CTL_OPM  = 3;
    localparam int CTL_DIR  = 4;
    localparam int CTL_ARPE = 7;

    // Bits of the control register that are implemented.
    localparam logic [7:0] CTL_DEFINED = 8'h9F;

    // One input transaction.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
    } t_item;

    // One result transaction.
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              update_event;
        logic              irq_line;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/pudrt_in_if.sv =====
// Handshake channel that carries input transactions of the timer.
`timescale 1ns / 1ps
`default_nettype none

interface pudrt_in_if;
    logic                           valid;
    logic                           ready;
    logic [pudrt_pkg::KIND_W-1:0]   kind;
    logic [pudrt_pkg::IDX_W-1:0]    reg_index;
    logic [pudrt_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output kind, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input reg_index, input write_data,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pudrt_out_if.sv =====
// Handshake channel that carries result transactions of the timer.
`timescale 1ns / 1ps
`default_nettype none

interface pudrt_out_if;
    logic                           valid;
    logic                           ready;
    logic [pudrt_pkg::DATA_W-1:0]   read_data;
    logic                           update_event;
    logic                           irq_line;

    modport source (output valid, output read_data, output update_event, output irq_line,
                    input ready);
    modport sink   (input valid, input read_data, input update_event, input irq_line,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pudrt_core.sv =====
// Timer register file and single-step state update for one transaction.
`timescale 1ns / 1ps
`default_nettype none

module pudrt_core #(
    parameter int COUNTER_WIDTH = pudrt_pkg::DEFAULT_COUNTER_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire pudrt_pkg::t_item i_item,
    output pudrt_pkg::t_result    o_result
);

    localparam int W = COUNTER_WIDTH;

    // Architectural state.
    logic [7:0]                     r_ctrl,     n_ctrl;
    logic                           r_irq_en,   n_irq_en;
    logic                           r_flag,     n_flag;
    logic [W-1:0]                   r_cnt,      n_cnt;
    logic [pudrt_pkg::DATA_W-1:0]   r_psc_pre,  n_psc_pre;
    logic [pudrt_pkg::DATA_W-1:0]   r_psc_act,  n_psc_act;
    logic [pudrt_pkg::DATA_W-1:0]   r_psc_cnt,  n_psc_cnt;
    logic [W-1:0]                   r_arr_pre,  n_arr_pre;
    logic [W-1:0]                   r_arr_act,  n_arr_act;

    logic                           fire_req;
    logic                           fire_set;
    logic                           cnt_reload;
    logic                           ev;
    logic [pudrt_pkg::DATA_W-1:0]   rd;
    logic [W-1:0]                   data_w;

    assign data_w = W'(i_item.write_data);

    // Next-state logic for one transaction.
    always_comb begin
        n_ctrl     = r_ctrl;
        n_irq_en   = r_irq_en;
        n_flag     = r_flag;
        n_cnt      = r_cnt;
        n_psc_pre  = r_psc_pre;
        n_psc_act  = r_psc_act;
        n_psc_cnt  = r_psc_cnt;
        n_arr_pre  = r_arr_pre;
        n_arr_act  = r_arr_act;
        fire_req   = 1'b0;
        fire_set   = 1'b0;
        cnt_reload = 1'b0;
        ev         = 1'b0;
        rd         = '0;

        case (i_item.kind)
            pudrt_pkg::KIND_TICK: begin
                if (r_ctrl[pudrt_pkg::CTL_EN]) begin
                    if (r_psc_cnt >= r_psc_act) begin
                        n_psc_cnt = '0;
                        // A zero reload value holds the counter.
                        if (r_arr_act != '0) begin
                            if (r_ctrl[pudrt_pkg::CTL_DIR]) begin
                                if (r_cnt == '0) begin
                                    fire_req   = 1'b1;
                                    fire_set   = 1'b1;
                                    cnt_reload = 1'b1;
                                end else begin
                                    n_cnt = r_cnt - W'(1);
                                end
                            end else begin
                                if (r_cnt == r_arr_act) begin
                                    n_cnt    = '0;
                                    fire_req = 1'b1;
                                    fire_set = 1'b1;
                                end else begin
                                    n_cnt = r_cnt + W'(1);
                                end
                            end
                        end
                    end else begin
                        n_psc_cnt = r_psc_cnt + 16'd1;
                    end
                end
            end
            pudrt_pkg::KIND_WRITE: begin
                case (i_item.reg_index)
                    pudrt_pkg::REG_CTRL: begin
                        n_ctrl = i_item.write_data[7:0] & pudrt_pkg::CTL_DEFINED;
                    end
                    pudrt_pkg::REG_IRQ_EN: begin
                        n_irq_en = i_item.write_data[0];
                    end
                    pudrt_pkg::REG_STATUS: begin
                        n_flag = r_flag & i_item.write_data[0];
                    end
                    pudrt_pkg::REG_EGR: begin
                        if (i_item.write_data[0]) begin
                            fire_req  = 1'b1;
                            fire_set  = !r_ctrl[pudrt_pkg::CTL_URS];
                            n_psc_cnt = '0;
                            if (r_ctrl[pudrt_pkg::CTL_DIR]) begin
                                cnt_reload = 1'b1;
                            end else begin
                                n_cnt = '0;
                            end
                        end
                    end
                    pudrt_pkg::REG_CNT: begin
                        n_cnt = data_w;
                    end
                    pudrt_pkg::REG_PSC: begin
                        n_psc_pre = i_item.write_data;
                    end
                    pudrt_pkg::REG_ARR: begin
                        n_arr_pre = data_w;
                        if (!r_ctrl[pudrt_pkg::CTL_ARPE]) begin
                            n_arr_act = data_w;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            pudrt_pkg::KIND_READ: begin
                case (i_item.reg_index)
                    pudrt_pkg::REG_CTRL:   rd = {8'd0, r_ctrl};
                    pudrt_pkg::REG_IRQ_EN: rd = {15'd0, r_irq_en};
                    pudrt_pkg::REG_STATUS: rd = {15'd0, r_flag};
                    pudrt_pkg::REG_CNT:    rd = pudrt_pkg::DATA_W'(r_cnt);
                    pudrt_pkg::REG_PSC:    rd = r_psc_pre;
                    pudrt_pkg::REG_ARR:    rd = pudrt_pkg::DATA_W'(r_arr_pre);
                    default:               rd = '0;
                endcase
            end
            default: begin
            end
        endcase

        // Update event if !UDIS: copy preloads, set flag on fire_set, stop in OPM.
        if (fire_req && !r_ctrl[pudrt_pkg::CTL_UDIS]) begin
            n_psc_act = r_psc_pre;
            n_arr_act = r_arr_pre;
            if (fire_set) begin
                n_flag = 1'b1;
            end
            if (r_ctrl[pudrt_pkg::CTL_OPM]) begin
                n_ctrl[pudrt_pkg::CTL_EN] = 1'b0;
            end
            ev = 1'b1;
        end

        // Counting down restarts from the reload value after any copy.
        if (cnt_reload) begin
            n_cnt = n_arr_act;
        end
    end

    // Result of this transaction, seen after the state update.
    always_comb begin
        o_result.read_data    = rd;
        o_result.update_event = ev;
        o_result.irq_line     = n_flag & n_irq_en;
    end

    // State registers, updated once per processed transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= '0;
            r_irq_en  <= 1'b0;
            r_flag    <= 1'b0;
            r_cnt     <= '0;
            r_psc_pre <= '0;
            r_psc_act <= '0;
            r_psc_cnt <= '0;
            r_arr_pre <= '1;
            r_arr_act <= '1;
        end else if (i_step) begin
            r_ctrl    <= n_ctrl;
            r_irq_en  <= n_irq_en;
            r_flag    <= n_flag;
            r_cnt     <= n_cnt;
            r_psc_pre <= n_psc_pre;
            r_psc_act <= n_psc_act;
            r_psc_cnt <= n_psc_cnt;
            r_arr_pre <= n_arr_pre;
            r_arr_act <= n_arr_act;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prescaled_updown_reload_timer.sv =====
// A transaction is captured in the input register and its result in the result register,
// since the input register feeds the result register through the step logic.
// Throughput: one transaction per cycle while the output is not stalled; the input register
// and the result register each hold one transaction, and the state steps once per transaction.
// Reset (synchronous, active low) clears the valid bits of both pipeline registers, the
// control, flag, counter and prescaler state, and sets both reload registers to all ones.
`timescale 1ns / 1ps
`default_nettype none

module prescaled_updown_reload_timer #(
    parameter int COUNTER_WIDTH = pudrt_pkg::DEFAULT_COUNTER_WIDTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pudrt_in_if.sink    i_in_ch,
    pudrt_out_if.source o_out_ch
);

    logic                r_in_valid;
    pudrt_pkg::t_item    r_in_item;
    logic                r_out_valid;
    pudrt_pkg::t_result  r_out_res;
    pudrt_pkg::t_result  core_res;
    logic                advance;

    // The held transaction moves on when the result register is free or drains.
    assign advance        = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready  = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in_item.kind       <= i_in_ch.kind;
            r_in_item.reg_index  <= i_in_ch.reg_index;
            r_in_item.write_data <= i_in_ch.write_data;
        end
    end

    // Timer state and step logic.
    pudrt_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .o_result (core_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= core_res;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.read_data    = r_out_res.read_data;
    assign o_out_ch.update_event = r_out_res.update_event;
    assign o_out_ch.irq_line     = r_out_res.irq_line;

    // A held transaction that cannot move keeps its contents.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_item))
        else $error("held input transaction changed while stalled");

    // Every processed transaction lands in the result register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed transaction did not reach the result register");

    // Only reads return data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_item.kind != pudrt_pkg::KIND_READ) |-> core_res.read_data == '0)
        else $error("read data returned for a transaction that is not a read");

    // Update events come only from ticks or from an event-generate write.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && core_res.update_event |->
            (r_in_item.kind == pudrt_pkg::KIND_TICK) ||
            ((r_in_item.kind == pudrt_pkg::KIND_WRITE) &&
             (r_in_item.reg_index == pudrt_pkg::REG_EGR)))
        else $error("update event from a transaction that cannot cause one");

endmodule

`default_nettype wire
